// ===== rtl/ilc_pkg.sv =====
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types and codes for the interval list cut block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilc_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CUT   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef logic [2:0] cell_cmd_t;

    localparam cell_cmd_t CMD_HOLD      = 3'd0;
    localparam cell_cmd_t CMD_LOAD      = 3'd1;
    localparam cell_cmd_t CMD_SET_START = 3'd2;
    localparam cell_cmd_t CMD_SET_END   = 3'd3;
    localparam cell_cmd_t CMD_SPLIT_HI  = 3'd4;
    localparam cell_cmd_t CMD_FROM_PREV = 3'd5;
    localparam cell_cmd_t CMD_FROM_NEXT = 3'd6;
    localparam cell_cmd_t CMD_NEXT_END  = 3'd7;

    typedef struct packed {
        logic zero;
        logic start_hit;
        logic end_hit;
        logic contained;
        logic adj;
    } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/interval_list_cut.sv =====
// ----------------------------------------------------------------------------
// interval_list_cut
// Ordered table of address intervals built as a row of slot cells. The first
// all-zero slot ends the list. Input beats carry an opcode in tuser (write
// slot, cut range, read slot, no-op); each input beat yields one output beat
// with the live count, the read slot (zero unless a read) and a table-full
// flag for a refused split.
// Items are processed one at a time. A read or no-op runs only the count step
// and a write loads its slot first. A cut runs terminator search, match,
// select and apply, then a merge pass of the same steps, then count; with no
// match it skips apply and the merge pass, and the merge skips apply when no
// entries touch. The next beat is taken the cycle after the result moves to
// the output register. Each step is one registered pass over the cell row.
// Reset empties the table (all slots zero) and drops the output valid flag.
// When m_axis_tready is low the result holds in the output register; one
// more item may be taken and computed, then it waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_list_cut
    import ilc_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // entry_index, range_start, range_end
    input  wire logic [1:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // entry_count, read_start, read_end
    output logic [0:0]       m_axis_tuser   // table_full
);

    localparam int RD_N = (ENTRIES < 32) ? ENTRIES : 32;
    localparam int NW   = ($clog2(ENTRIES + 1) > 6) ? $clog2(ENTRIES + 1) : 6;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_SPLIT = 2'd2;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WRITE     = 4'd1;
    localparam logic [3:0] S_CUT_Z     = 4'd2;
    localparam logic [3:0] S_CUT_MATCH = 4'd3;
    localparam logic [3:0] S_CUT_SEL   = 4'd4;
    localparam logic [3:0] S_CUT_APPLY = 4'd5;
    localparam logic [3:0] S_MRG_Z     = 4'd6;
    localparam logic [3:0] S_MRG_MATCH = 4'd7;
    localparam logic [3:0] S_MRG_SEL   = 4'd8;
    localparam logic [3:0] S_MRG_APPLY = 4'd9;
    localparam logic [3:0] S_CNT_Z     = 4'd10;
    localparam logic [3:0] S_CNT_OUT   = 4'd11;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [1:0]  op_reg;
    logic [4:0]  idx_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] rs_reg;
    logic [31:0] re_reg;
    logic        full_reg;
    logic        tfull_reg;
    logic [1:0]  act_reg;

    logic [ENTRIES-1:0] zfirst_reg;
    logic [ENTRIES-1:0] live_reg;
    logic [ENTRIES-1:0] sm_reg;
    logic [ENTRIES-1:0] em_reg;
    logic [ENTRIES-1:0] cm_reg;
    logic [ENTRIES-1:0] adj_reg;
    logic [ENTRIES-1:0] sel_reg;

    logic [5:0]  out_cnt_reg;
    logic [31:0] out_rs_reg;
    logic [31:0] out_re_reg;
    logic        out_full_reg;

    logic [4:0]  in_idx;
    logic [31:0] in_a;
    logic [31:0] in_b;
    logic [1:0]  in_op;
    logic        in_acc;
    logic        out_load;

    logic [31:0]        cell_start [ENTRIES];
    logic [31:0]        cell_end   [ENTRIES];
    cell_flags_t        flags      [ENTRIES];
    cell_cmd_t          cmd_c      [ENTRIES];

    logic [ENTRIES-1:0] zmask;
    logic [ENTRIES-1:0] smask;
    logic [ENTRIES-1:0] emask;
    logic [ENTRIES-1:0] cmask;
    logic [ENTRIES-1:0] amask;
    logic [ENTRIES-1:0] zfirst_c;
    logic [ENTRIES-1:0] live_c;
    logic [ENTRIES-1:0] first_s;
    logic [ENTRIES-1:0] first_e;
    logic [ENTRIES-1:0] first_c;
    logic [ENTRIES-1:0] first_a;
    logic [ENTRIES-1:0] sel_up;
    logic [ENTRIES-1:0] gt_sel;
    logic [31:0]        rd_start;
    logic [31:0]        rd_end;
    logic [NW-1:0]      cnt_wide;
    logic [5:0]         cnt_sat;

    assign in_idx = s_axis_tdata[4:0];
    assign in_a   = s_axis_tdata[36:5];
    assign in_b   = s_axis_tdata[68:37];
    assign in_op  = s_axis_tuser;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_CNT_OUT) && (!out_valid_reg || m_axis_tready);

    // cell row
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [31:0] ps;
        logic [31:0] pe;
        logic [31:0] ns;
        logic [31:0] ne;

        if (g == 0)
        begin : g_first
            assign ps = '0;
            assign pe = '0;
        end
        else
        begin : g_mid
            assign ps = cell_start[g-1];
            assign pe = cell_end[g-1];
        end

        if (g == ENTRIES - 1)
        begin : g_last
            assign ns = '0;
            assign ne = '0;
        end
        else
        begin : g_body
            assign ns = cell_start[g+1];
            assign ne = cell_end[g+1];
        end

        ilc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd_c[g]),
            .range_start (a_reg),
            .range_end   (b_reg),
            .prev_start  (ps),
            .prev_end    (pe),
            .next_start  (ns),
            .next_end    (ne),
            .ent_start   (cell_start[g]),
            .ent_end     (cell_end[g]),
            .flags       (flags[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            zmask[i] = flags[i].zero;
            smask[i] = flags[i].start_hit;
            emask[i] = flags[i].end_hit;
            cmask[i] = flags[i].contained;
            amask[i] = flags[i].adj;
        end
    end

    assign zfirst_c = zmask & (~zmask + ENTRIES'(1));
    assign live_c   = zfirst_reg - ENTRIES'(1);
    assign first_s  = sm_reg & (~sm_reg + ENTRIES'(1));
    assign first_e  = em_reg & (~em_reg + ENTRIES'(1));
    assign first_c  = cm_reg & (~cm_reg + ENTRIES'(1));
    assign first_a  = adj_reg & (~adj_reg + ENTRIES'(1));
    assign sel_up   = sel_reg << 1;
    assign gt_sel   = ~(sel_up - ENTRIES'(1));

    // slot read at the input index
    always_comb
    begin
        rd_start = '0;
        rd_end   = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (in_idx == 5'(i))
            begin
                rd_start = cell_start[i];
                rd_end   = cell_end[i];
            end
        end
    end

    // position of the terminator
    always_comb
    begin
        cnt_wide = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (zfirst_reg[i])
            begin
                cnt_wide = cnt_wide | NW'(i);
            end
        end
        if (zfirst_reg == '0)
        begin
            cnt_wide = NW'(ENTRIES);
        end
        cnt_sat = (cnt_wide > NW'(63)) ? 6'd63 : cnt_wide[5:0];
    end

    // per-slot commands
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cmd_c[i] = CMD_HOLD;
            if (state_reg == S_WRITE)
            begin
                if ((i < RD_N) && (idx_reg == 5'(i)))
                begin
                    cmd_c[i] = CMD_LOAD;
                end
            end
            else if (state_reg == S_CUT_APPLY)
            begin
                case (act_reg)
                    ACT_START:
                    begin
                        if (sel_reg[i])
                        begin
                            cmd_c[i] = CMD_SET_START;
                        end
                    end
                    ACT_END:
                    begin
                        if (sel_reg[i])
                        begin
                            cmd_c[i] = CMD_SET_END;
                        end
                    end
                    ACT_SPLIT:
                    begin
                        if (sel_reg[i])
                        begin
                            cmd_c[i] = CMD_SET_END;
                        end
                        else if (sel_up[i])
                        begin
                            cmd_c[i] = CMD_SPLIT_HI;
                        end
                        else if (gt_sel[i] && (live_reg[i] || zfirst_reg[i]))
                        begin
                            cmd_c[i] = CMD_FROM_PREV;
                        end
                    end
                    default: cmd_c[i] = CMD_HOLD;
                endcase
            end
            else if (state_reg == S_MRG_APPLY)
            begin
                if (sel_reg[i])
                begin
                    cmd_c[i] = CMD_NEXT_END;
                end
                else if (gt_sel[i])
                begin
                    cmd_c[i] = CMD_FROM_NEXT;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_op == OP_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (in_op == OP_CUT)
                    begin
                        state_next = S_CUT_Z;
                    end
                    else
                    begin
                        state_next = S_CNT_Z;
                    end
                end
            end
            S_WRITE:     state_next = S_CNT_Z;
            S_CUT_Z:     state_next = S_CUT_MATCH;
            S_CUT_MATCH: state_next = S_CUT_SEL;
            S_CUT_SEL:
            begin
                if ((sm_reg != '0) || (em_reg != '0) || ((cm_reg != '0) && !tfull_reg))
                begin
                    state_next = S_CUT_APPLY;
                end
                else
                begin
                    state_next = S_CNT_Z;
                end
            end
            S_CUT_APPLY: state_next = S_MRG_Z;
            S_MRG_Z:     state_next = S_MRG_MATCH;
            S_MRG_MATCH: state_next = S_MRG_SEL;
            S_MRG_SEL:   state_next = (adj_reg != '0) ? S_MRG_APPLY : S_CNT_Z;
            S_MRG_APPLY: state_next = S_CNT_Z;
            S_CNT_Z:     state_next = S_CNT_OUT;
            S_CNT_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= '0;
            idx_reg      <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            full_reg     <= 1'b0;
            rs_reg       <= '0;
            re_reg       <= '0;
            zfirst_reg   <= '0;
            live_reg     <= '0;
            sm_reg       <= '0;
            em_reg       <= '0;
            cm_reg       <= '0;
            tfull_reg    <= 1'b0;
            sel_reg      <= '0;
            act_reg      <= ACT_START;
            adj_reg      <= '0;
            out_cnt_reg  <= '0;
            out_rs_reg   <= '0;
            out_re_reg   <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                op_reg   <= in_op;
                idx_reg  <= in_idx;
                a_reg    <= in_a;
                b_reg    <= in_b;
                full_reg <= 1'b0;
                rs_reg   <= (in_op == OP_READ) ? rd_start : '0;
                re_reg   <= (in_op == OP_READ) ? rd_end : '0;
            end

            if ((state_reg == S_CUT_Z) || (state_reg == S_MRG_Z) || (state_reg == S_CNT_Z))
            begin
                zfirst_reg <= zfirst_c;
            end

            if (state_reg == S_CUT_MATCH)
            begin
                live_reg  <= live_c;
                sm_reg    <= live_c & smask;
                em_reg    <= live_c & emask;
                cm_reg    <= live_c & cmask;
                tfull_reg <= (zfirst_reg == '0);
            end

            if (state_reg == S_CUT_SEL)
            begin
                if (sm_reg != '0)
                begin
                    sel_reg <= first_s;
                    act_reg <= ACT_START;
                end
                else if (em_reg != '0)
                begin
                    sel_reg <= first_e;
                    act_reg <= ACT_END;
                end
                else
                begin
                    sel_reg  <= first_c;
                    act_reg  <= ACT_SPLIT;
                    full_reg <= (cm_reg != '0) && tfull_reg;
                end
            end

            if (state_reg == S_MRG_MATCH)
            begin
                live_reg <= live_c;
                adj_reg  <= amask & live_c & (live_c >> 1);
            end

            if (state_reg == S_MRG_SEL)
            begin
                sel_reg <= first_a;
            end

            if (out_load)
            begin
                out_cnt_reg  <= cnt_sat;
                out_rs_reg   <= rs_reg;
                out_re_reg   <= re_reg;
                out_full_reg <= full_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_re_reg, out_rs_reg, out_cnt_reg};
    assign m_axis_tuser  = out_full_reg;

    a_sel_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_reg))
        else $error("slot select not one-hot");

    a_zfirst_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(zfirst_reg))
        else $error("terminator mark not one-hot");

    a_full_only_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && full_reg) |-> (op_reg == OP_CUT))
        else $error("table full flagged on a non-cut item");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken twice in a row");

endmodule

`default_nettype wire

// ===== rtl/ilc_cell.sv =====
// ----------------------------------------------------------------------------
// ilc_cell
// One table slot: holds an interval, loads or trims it from the current range,
// compares it against that range and loads from its neighbors when entries shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_cell
    import ilc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_cmd_t   cmd,
    input  wire logic [31:0] range_start,
    input  wire logic [31:0] range_end,
    input  wire logic [31:0] prev_start,
    input  wire logic [31:0] prev_end,
    input  wire logic [31:0] next_start,
    input  wire logic [31:0] next_end,
    output logic [31:0]      ent_start,
    output logic [31:0]      ent_end,
    output cell_flags_t      flags
);

    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic [31:0] start_next;
    logic [31:0] end_next;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
            end
            CMD_LOAD:
            begin
                start_next = range_start;
                end_next   = range_end;
            end
            CMD_SET_START: start_next = range_end + 32'd1;
            CMD_SET_END:   end_next   = range_start - 32'd1;
            CMD_SPLIT_HI:
            begin
                start_next = range_end + 32'd1;
                end_next   = prev_end;
            end
            CMD_FROM_PREV:
            begin
                start_next = prev_start;
                end_next   = prev_end;
            end
            CMD_FROM_NEXT:
            begin
                start_next = next_start;
                end_next   = next_end;
            end
            CMD_NEXT_END:  end_next = next_end;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    assign ent_start       = start_reg;
    assign ent_end         = end_reg;
    assign flags.zero      = (start_reg == '0) && (end_reg == '0);
    assign flags.start_hit = (start_reg == range_start);
    assign flags.end_hit   = (end_reg == range_end);
    assign flags.contained = (range_start > start_reg) && (range_end < end_reg);
    assign flags.adj       = ((end_reg + 32'd1) == next_start);

endmodule

`default_nettype wire
